@@ hw/rtl/reb_pkg.sv @@
`timescale 1ns / 1ps

package reb_pkg;

	// Default build settings
	localparam int TICK_WIDTH_DEF   = 32;
	localparam int DETENT_STEPS_DEF = 4;

	// Fixed field widths
	localparam int CFG_WIDTH   = 16;
	localparam int EVT_TICK_W  = 32;
	localparam int NOW_TICK_W  = 32;

	// Register reset values
	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

	// Register indexes
	localparam logic [0:0] REG_DEBOUNCE   = 1'b0;
	localparam logic [0:0] REG_LONG_PRESS = 1'b1;

	typedef enum logic [1:0] {
		CMD_AB_EDGE  = 2'd0,
		CMD_SW_EDGE  = 2'd1,
		CMD_LP_CHECK = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EVT_CW         = 3'd0,
		EVT_CCW        = 3'd1,
		EVT_SHORT      = 3'd2,
		EVT_REL_LONG   = 3'd3,
		EVT_LONG_PRESS = 3'd4
	} evt_code_t;

	// One optional event from a decoder
	typedef struct packed {
		logic      fire;
		evt_code_t code;
	} reb_evt_t;

	// Quadrature transition table: index = {previous phase, current phase}
	function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default:                  d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

@@ hw/rtl/reb_quad.sv @@
`timescale 1ns / 1ps

module reb_quad
	import reb_pkg::*;
#(
	parameter int DETENT_STEPS = DETENT_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     commit,
	input  logic     level_a,
	input  logic     level_b,
	output reb_evt_t evt
);

	localparam int ACC_W = $clog2(DETENT_STEPS + 1) + 1;
	localparam logic signed [ACC_W-1:0] STEP_POS = ACC_W'(DETENT_STEPS);
	localparam logic signed [ACC_W-1:0] STEP_NEG = -STEP_POS;

	logic [1:0]              prev_phase_q;
	logic signed [ACC_W-1:0] accum_q;
	logic [1:0]              cur_phase;
	logic signed [1:0]       delta;
	logic signed [ACC_W-1:0] sum;

	// Look up the step and detect a full detent
	always_comb begin
		cur_phase = {level_a, level_b};
		delta     = quad_delta({prev_phase_q, cur_phase});
		sum       = accum_q + ACC_W'(delta);
		evt.fire  = 1'b0;
		evt.code  = EVT_CW;
		if (sum >= STEP_POS) begin
			evt.fire = 1'b1;
			evt.code = EVT_CW;
		end else if (sum <= STEP_NEG) begin
			evt.fire = 1'b1;
			evt.code = EVT_CCW;
		end
	end

	// Advance phase and accumulator on each committed edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= 2'd0;
			accum_q      <= '0;
		end else if (commit) begin
			prev_phase_q <= cur_phase;
			accum_q      <= evt.fire ? '0 : sum;
		end
	end

endmodule

@@ hw/rtl/reb_button.sv @@
`timescale 1ns / 1ps

module reb_button
	import reb_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  cmd_t                  cmd,
	input  logic [TICK_WIDTH-1:0] tick,
	input  logic                  level_sw,
	input  logic [CFG_WIDTH-1:0]  db_limit,
	input  logic [CFG_WIDTH-1:0]  lp_limit,
	output reb_evt_t              evt
);

	logic [TICK_WIDTH-1:0] last_edge_q;
	logic [TICK_WIDTH-1:0] press_start_q;
	logic                  held_q;
	logic                  long_q;

	logic [TICK_WIDTH-1:0] since_edge;
	logic [TICK_WIDTH-1:0] since_press;
	logic                  edge_ok;
	logic                  lp_due;
	logic                  held_d;
	logic                  long_d;
	logic                  take_edge;
	logic                  start_press;

	// Decide the next flags and the event for the current item
	always_comb begin
		since_edge  = tick - last_edge_q;
		since_press = tick - press_start_q;
		edge_ok     = since_edge >= TICK_WIDTH'(db_limit);
		lp_due      = held_q && !long_q && (since_press >= TICK_WIDTH'(lp_limit));
		held_d      = held_q;
		long_d      = long_q;
		take_edge   = 1'b0;
		start_press = 1'b0;
		evt.fire    = 1'b0;
		evt.code    = EVT_SHORT;
		case (cmd)
			CMD_SW_EDGE: begin
				if (edge_ok) begin
					take_edge = 1'b1;
					if (!level_sw) begin
						if (!held_q) begin
							start_press = 1'b1;
							held_d      = 1'b1;
							long_d      = 1'b0;
						end
					end else if (held_q) begin
						evt.fire = 1'b1;
						evt.code = long_q ? EVT_REL_LONG : EVT_SHORT;
						held_d   = 1'b0;
						long_d   = 1'b0;
					end
				end
			end
			CMD_LP_CHECK: begin
				if (lp_due) begin
					if (level_sw) begin
						held_d = 1'b0;
					end else begin
						long_d   = 1'b1;
						evt.fire = 1'b1;
						evt.code = EVT_LONG_PRESS;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Update button state on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q   <= '0;
			press_start_q <= '0;
			held_q        <= 1'b0;
			long_q        <= 1'b0;
		end else if (commit) begin
			held_q <= held_d;
			long_q <= long_d;
			if (take_edge) begin
				last_edge_q <= tick;
			end
			if (start_press) begin
				press_start_q <= tick;
			end
		end
	end

endmodule

@@ hw/rtl/rotary_encoder_button_events.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    command, now_tick, level_a, level_b, level_sw
// out       out        out_valid / out_ready  event_code, event_tick
// cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
// An item waits in the input register until it moves on; its event is then
// loaded into the result register, from which it can be taken.
// Throughput is one item per cycle, apart from the wait described next; the
// single pass from the input register through the encoder and button logic
// to the result register sets it.
// An item that gives an event waits in the input register while the result
// register is full and not being taken; items without an event never wait.
// Reset clears the valid flags and the encoder and button state, loads the
// default tick settings, and leaves both channels empty.

module rotary_encoder_button_events
	import reb_pkg::*;
#(
	parameter int TICK_WIDTH   = TICK_WIDTH_DEF,
	parameter int DETENT_STEPS = DETENT_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [NOW_TICK_W-1:0] now_tick,
	input  logic                  level_a,
	input  logic                  level_b,
	input  logic                  level_sw,
	// events
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_code,
	output logic [EVT_TICK_W-1:0] event_tick,
	// configuration
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_WIDTH-1:0]  cfg_data
);

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [TICK_WIDTH-1:0] tick_s1;
	logic                  a_s1;
	logic                  b_s1;
	logic                  sw_s1;

	logic                  out_valid_q;
	evt_code_t             event_code_q;
	logic [EVT_TICK_W-1:0] event_tick_q;

	logic [CFG_WIDTH-1:0]  debounce_q;
	logic [CFG_WIDTH-1:0]  long_press_q;

	reb_evt_t              quad_evt;
	reb_evt_t              btn_evt;
	reb_evt_t              evt;
	logic                  out_free;
	logic                  advance;
	logic                  quad_commit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Pick the event for the item in the input register
	always_comb begin
		case (cmd_s1)
			CMD_AB_EDGE:  evt = quad_evt;
			CMD_SW_EDGE:  evt = btn_evt;
			CMD_LP_CHECK: evt = btn_evt;
			default:      evt = '{fire: 1'b0, code: EVT_CW};
		endcase
		out_free    = !out_valid_q || out_ready;
		advance     = valid_s1 && (!evt.fire || out_free);
		quad_commit = advance && (cmd_s1 == CMD_AB_EDGE);
	end

	assign in_ready = !valid_s1 || advance;

	// Input register: take a transfer whenever the slot is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd_t'(command);
			tick_s1 <= TICK_WIDTH'(now_tick);
			a_s1    <= level_a;
			b_s1    <= level_b;
			sw_s1   <= level_sw;
		end
	end

	reb_quad #(
		.DETENT_STEPS(DETENT_STEPS)
	) u_quad (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (quad_commit),
		.level_a (a_s1),
		.level_b (b_s1),
		.evt     (quad_evt)
	);

	reb_button #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_button (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (advance),
		.cmd      (cmd_s1),
		.tick     (tick_s1),
		.level_sw (sw_s1),
		.db_limit (debounce_q),
		.lp_limit (long_press_q),
		.evt      (btn_evt)
	);

	// Result register: load on an event, drop on a completed transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && evt.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt.fire) begin
			event_code_q <= evt.code;
			event_tick_q <= EVT_TICK_W'(tick_s1);
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_code_q;
	assign event_tick = event_tick_q;

`ifndef SYNTHESIS
	// An unused command never leaves an event behind
	a_unused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == CMD_UNUSED) |=> !$rose(out_valid_q))
		else $error("unused command produced an event");

	// A new event appears only after an item moved on
	a_event_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("event without a committed item");

	// A stalled input slot always holds an item
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a full result register");

	// Events carry only defined codes
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code <= 3'(EVT_LONG_PRESS)))
		else $error("undefined event code");
`endif

endmodule

@@ test/rotary_encoder_button_events_tb.sv @@
`timescale 1ns / 1ps

module rotary_encoder_button_events_tb;
	import reb_pkg::*;

	localparam int DETENT    = DETENT_STEPS_DEF;
	localparam int N_DIR     = 26;
	localparam int N_PHASES  = 5;
	localparam int PHASE_LEN = 150;

	// Step delta per {previous phase, current phase}
	localparam logic signed [1:0] QUAD_STEP [16] = '{
		 2'sd0, -2'sd1,  2'sd1,  2'sd0,
		 2'sd1,  2'sd0,  2'sd0, -2'sd1,
		-2'sd1,  2'sd0,  2'sd0,  2'sd1,
		 2'sd0,  2'sd1, -2'sd1,  2'sd0
	};

	// Phase sequence for clockwise rotation
	localparam logic [1:0] CW_ORDER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now;
		logic        a;
		logic        b;
		logic        sw;
		logic        typed;
		logic        typed_fire;
		evt_code_t   typed_code;
	} enc_item_t;

	typedef struct {
		evt_code_t   code;
		logic [31:0] tick;
	} event_rec_t;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [1:0]            command    = CMD_AB_EDGE;
	logic [NOW_TICK_W-1:0] now_tick   = '0;
	logic                  level_a    = 1'b0;
	logic                  level_b    = 1'b0;
	logic                  level_sw   = 1'b1;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [2:0]            event_code;
	logic [EVT_TICK_W-1:0] event_tick;
	logic                  cfg_we     = 1'b0;
	logic [0:0]            cfg_index  = REG_DEBOUNCE;
	logic [CFG_WIDTH-1:0]  cfg_data   = '0;

	rotary_encoder_button_events u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.now_tick   (now_tick),
		.level_a    (level_a),
		.level_b    (level_b),
		.level_sw   (level_sw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.event_tick (event_tick),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Directed rows: cmd, tick, a, b, sw, typed, fires, code
	enc_item_t dir_tbl [N_DIR] = '{
		// switch edge too early after reset
		'{CMD_SW_EDGE,  32'd5,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EVT_CW},
		// one clockwise detent
		'{CMD_AB_EDGE,  32'd10,   1'b1, 1'b0, 1'b1, 1'b1, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd11,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd12,   1'b0, 1'b1, 1'b1, 1'b1, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd13,   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, EVT_CW},
		// one counter-clockwise detent
		'{CMD_AB_EDGE,  32'd14,   1'b0, 1'b1, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd15,   1'b1, 1'b1, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd16,   1'b1, 1'b0, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd17,   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, EVT_CCW},
		// illegal jump and repeated phase
		'{CMD_AB_EDGE,  32'd18,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd19,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0, EVT_CW},
		'{CMD_AB_EDGE,  32'd20,   1'b0, 1'b0, 1'b1, 1'b0, 1'b0, EVT_CW},
		// short press
		'{CMD_SW_EDGE,  32'd100,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_SW_EDGE,  32'd150,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1, EVT_SHORT},
		// press, bounce, long press, release after long
		'{CMD_SW_EDGE,  32'd200,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_SW_EDGE,  32'd205,  1'b0, 1'b0, 1'b1, 1'b1, 1'b0, EVT_CW},
		'{CMD_LP_CHECK, 32'd1100, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_LP_CHECK, 32'd1200, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, EVT_LONG_PRESS},
		'{CMD_LP_CHECK, 32'd1300, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_SW_EDGE,  32'd1400, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, EVT_REL_LONG},
		// check finds the switch already up
		'{CMD_SW_EDGE,  32'd2000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EVT_CW},
		'{CMD_LP_CHECK, 32'd3000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, EVT_CW},
		'{CMD_SW_EDGE,  32'd3100, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, EVT_CW},
		// unused command at the top tick
		'{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, EVT_CW},
		// press and release across the tick wrap
		'{CMD_SW_EDGE, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, EVT_CW},
		'{CMD_SW_EDGE, 32'h0000_0010, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, EVT_SHORT}
	};

	enc_item_t  stim_q [$];
	enc_item_t  offer_q [$];
	event_rec_t pending_events [$];
	int         mismatch_cnt = 0;

	// Predictor state and registers
	logic [15:0] pr_debounce;
	logic [15:0] pr_long_press;
	logic [1:0]  pr_phase;
	int          pr_detent_acc;
	logic [31:0] pr_last_edge;
	logic [31:0] pr_press_start;
	logic        pr_held;
	logic        pr_long_done;

	// Generator view of time and settings
	logic [31:0] gen_time = 32'h20;
	int          gen_pos = 0;
	int unsigned gen_db = DEBOUNCE_RESET;
	int unsigned gen_lp = LONG_PRESS_RESET;

	// Receiver stall control
	int unsigned rx_cycle = 0;
	int          rx_mode = 0;
	int          hold_left = 0;
	bit          hold_done = 0;
	bit          want_hold = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic reset_predictor();
		pr_debounce    = DEBOUNCE_RESET;
		pr_long_press  = LONG_PRESS_RESET;
		pr_phase       = 2'd0;
		pr_detent_acc  = 0;
		pr_last_edge   = '0;
		pr_press_start = '0;
		pr_held        = 1'b0;
		pr_long_done   = 1'b0;
	endtask

	// Advance the predicted encoder/button state by one item
	task automatic predict_event(input cmd_t cmd, input logic [31:0] now, input logic a,
			input logic b, input logic sw, output bit fire, output evt_code_t code);
		logic [1:0]  cur;
		logic [31:0] span;
		fire = 1'b0;
		code = EVT_CW;
		case (cmd)
			CMD_AB_EDGE: begin
				cur = {a, b};
				pr_detent_acc += QUAD_STEP[{pr_phase, cur}];
				pr_phase = cur;
				if (pr_detent_acc >= DETENT) begin
					pr_detent_acc = 0;
					fire = 1'b1;
					code = EVT_CW;
				end else if (pr_detent_acc <= -DETENT) begin
					pr_detent_acc = 0;
					fire = 1'b1;
					code = EVT_CCW;
				end
			end
			CMD_SW_EDGE: begin
				span = now - pr_last_edge;
				if (span >= {16'd0, pr_debounce}) begin
					pr_last_edge = now;
					if (!sw) begin
						if (!pr_held) begin
							pr_held = 1'b1;
							pr_long_done = 1'b0;
							pr_press_start = now;
						end
					end else if (pr_held) begin
						fire = 1'b1;
						code = pr_long_done ? EVT_REL_LONG : EVT_SHORT;
						pr_held = 1'b0;
						pr_long_done = 1'b0;
					end
				end
			end
			CMD_LP_CHECK: begin
				span = now - pr_press_start;
				if (pr_held && !pr_long_done && span >= {16'd0, pr_long_press}) begin
					if (sw) begin
						pr_held = 1'b0;
					end else begin
						pr_long_done = 1'b1;
						fire = 1'b1;
						code = EVT_LONG_PRESS;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Track register writes, predict on input transfers, check output transfers
	always @(posedge clk) begin : scoreboard
		enc_item_t  row;
		bit         fire;
		evt_code_t  code;
		event_rec_t exp_ev;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE:   pr_debounce = cfg_data;
					REG_LONG_PRESS: pr_long_press = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				row = offer_q.pop_front();
				predict_event(cmd_t'(command), now_tick, level_a, level_b, level_sw, fire, code);
				if (row.typed) begin
					fire = row.typed_fire;
					code = row.typed_code;
				end
				if (fire)
					pending_events.push_back('{code, now_tick});
			end
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					$display("%0t: unexpected event, expected none, actual code %0d tick %h",
						$time, event_code, event_tick);
					mismatch_cnt++;
				end else begin
					exp_ev = pending_events.pop_front();
					if (event_code !== exp_ev.code) begin
						$display("%0t: event_code mismatch, expected %0d, actual %0d",
							$time, exp_ev.code, event_code);
						mismatch_cnt++;
					end
					if (event_tick !== exp_ev.tick) begin
						$display("%0t: event_tick mismatch, expected %h, actual %h",
							$time, exp_ev.tick, event_tick);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	// Stall the result side on a changing pattern, with one long hold-off
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			rx_mode = $urandom_range(0, 3);
		if (want_hold && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= (rx_cycle % 4 == 0);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	task automatic push_item(input cmd_t cmd, input logic [31:0] t, input logic a,
			input logic b, input logic sw);
		stim_q.push_back('{cmd, t, a, b, sw, 1'b0, 1'b0, EVT_CW});
	endtask

	// Build rotations, presses and noise shaped by the current settings
	task automatic gen_gestures(input int n_items);
		int steps;
		int dir;
		int k;
		int start;
		start = stim_q.size();
		while (stim_q.size() - start < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					dir = $urandom_range(0, 1) ? 1 : -1;
					steps = 4 * $urandom_range(1, 3) + $urandom_range(0, 2);
					for (k = 0; k < steps; k++) begin
						// mostly forward, with an occasional backward jitter
						gen_pos = (gen_pos + (($urandom_range(0, 9) == 0) ? -dir : dir) + 4) % 4;
						gen_time += $urandom_range(1, 50);
						push_item(CMD_AB_EDGE, gen_time, CW_ORDER[gen_pos][1],
							CW_ORDER[gen_pos][0], 1'($urandom_range(0, 1)));
					end
				end
				4, 5, 6, 7: begin
					gen_time += gen_db + $urandom_range(0, 40);
					push_item(CMD_SW_EDGE, gen_time, 1'($urandom), 1'($urandom), 1'b0);
					// bounces inside the debounce window
					for (k = $urandom_range(0, 2); k > 0; k--) begin
						gen_time += $urandom_range(0, (gen_db > 0) ? gen_db - 1 : 0);
						push_item(CMD_SW_EDGE, gen_time, 1'($urandom), 1'($urandom),
							1'($urandom));
					end
					for (k = $urandom_range(0, 3); k > 0; k--) begin
						gen_time += $urandom_range(0, gen_lp / 2 + 1);
						push_item(CMD_LP_CHECK, gen_time, 1'($urandom), 1'($urandom),
							$urandom_range(0, 7) == 0);
					end
					if ($urandom_range(0, 1)) begin
						gen_time += gen_lp + $urandom_range(0, 20);
						push_item(CMD_LP_CHECK, gen_time, 1'($urandom), 1'($urandom),
							$urandom_range(0, 5) == 0);
						if ($urandom_range(0, 1))
							push_item(CMD_LP_CHECK, gen_time + 1, 1'($urandom),
								1'($urandom), 1'b0);
					end
					// release, now and then too early to pass the debounce
					if ($urandom_range(0, 5) != 0)
						gen_time += gen_db + $urandom_range(0, 40);
					else
						gen_time += $urandom_range(0, 3);
					push_item(CMD_SW_EDGE, gen_time, 1'($urandom), 1'($urandom), 1'b1);
				end
				default: begin
					push_item(cmd_t'($urandom_range(0, 3)),
						($urandom_range(0, 3) == 0) ? 32'($urandom) :
							gen_time + $urandom_range(0, gen_db + 5),
						1'($urandom), 1'($urandom), 1'($urandom));
				end
			endcase
		end
	endtask

	// Offer queued items in bursts with random gaps
	task automatic drive_items();
		enc_item_t it;
		int burst;
		int gap;
		while (stim_q.size() > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && stim_q.size() > 0) begin
				it = stim_q.pop_front();
				offer_q.push_back(it);
				in_valid <= 1'b1;
				command  <= it.cmd;
				now_tick <= it.now;
				level_a  <= it.a;
				level_b  <= it.b;
				level_sw <= it.sw;
				@(posedge clk);
				while (!in_ready)
					@(posedge clk);
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic write_cfg(input logic [15:0] db, input logic [15:0] lp);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data  <= db;
		@(posedge clk);
		cfg_index <= REG_LONG_PRESS;
		cfg_data  <= lp;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gen_db = db;
		gen_lp = lp;
	endtask

	// Drain expected events, then let the input and result registers empty
	task automatic settle();
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : main_seq
		int p;
		int k;
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIR; k++)
			stim_q.push_back(dir_tbl[k]);

		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				1:       write_cfg(16'd0, 16'd0);
				2:       write_cfg(16'hFFFF, 16'hFFFF);
				3:       write_cfg(16'($urandom), 16'($urandom));
				4:       write_cfg(16'($urandom_range(1, 8)), 16'($urandom_range(10, 60)));
				default: ;
			endcase
			// hold the result side off while items keep coming
			if (p == 2)
				want_hold = 1'b1;
			gen_gestures(PHASE_LEN);
			drive_items();
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
